// ----- sv/rsf_pkg.sv -----
`timescale 1ns / 1ps

package rsf_pkg;

    localparam int SEQ_W  = 32;
    localparam int TIME_W = 64;
    localparam int TMO_W  = 32;

    localparam logic [1:0] FUNC_CHECK  = 2'd0;
    localparam logic [1:0] FUNC_MARK   = 2'd1;
    localparam logic [1:0] FUNC_CLEAR  = 2'd2;
    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    localparam logic [1:0] ADDR_TIMEOUT = 2'd0;

    typedef struct packed {
        logic              vld;
        logic [SEQ_W-1:0]  seq;
        logic [TIME_W-1:0] now;
        logic              hit;
    } tok_t;

endpackage

// ----- sv/rsf_cell.sv -----
`timescale 1ns / 1ps

module rsf_cell (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  rsf_pkg::tok_t             tok_in,
    output rsf_pkg::tok_t             tok_out,
    input  logic                      clr_all,
    input  logic                      wr_en,
    input  logic [rsf_pkg::SEQ_W-1:0] wr_seq,
    input  logic [rsf_pkg::TIME_W-1:0] wr_time,
    input  logic [rsf_pkg::TMO_W-1:0] timeout_ms
);
    import rsf_pkg::*;

    logic              valid_reg;
    logic              valid_next;
    logic [SEQ_W-1:0]  seq_reg;
    logic [SEQ_W-1:0]  seq_next;
    logic [TIME_W-1:0] time_reg;
    logic [TIME_W-1:0] time_next;
    tok_t              tok_reg;
    tok_t              tok_next;

    logic [TIME_W-1:0] age;
    logic              match;
    logic              expired;

    assign age     = tok_in.now - time_reg;
    assign match   = tok_in.vld && valid_reg && (seq_reg == tok_in.seq);
    assign expired = age > {{(TIME_W-TMO_W){1'b0}}, timeout_ms};

    always_comb begin
        valid_next = valid_reg;
        seq_next   = seq_reg;
        time_next  = time_reg;
        if (clr_all) begin
            valid_next = 1'b0;
        end else if (wr_en) begin
            valid_next = 1'b1;
            seq_next   = wr_seq;
            time_next  = wr_time;
        end else if (match && expired) begin
            valid_next = 1'b0;
        end
        tok_next     = tok_in;
        tok_next.hit = tok_in.hit | (match & ~expired);
    end

    always_ff @(posedge aclk) begin
        seq_reg  <= seq_next;
        time_reg <= time_next;
        if (!aresetn) begin
            valid_reg <= 1'b0;
            tok_reg   <= '0;
        end else begin
            valid_reg <= valid_next;
            tok_reg   <= tok_next;
        end
    end

    assign tok_out = tok_reg;

endmodule

// ----- sv/replay_seen_filter_with_expiry_core.sv -----
`timescale 1ns / 1ps

// Replay filter with expiry. Each input beat carries an operation (check, mark
// or clear), a 32-bit sequence number and the current 64-bit millisecond time.
// Each input beat yields exactly one output beat carrying the fresh flag.
// Entries live in a row of REPLAY_DEPTH cells; a check or mark sends a query
// token down the row, one cell per cycle, and each cell compares, expires and
// flags its own entry as the token passes.
// A check or mark gives its result beat once the token has left the last cell;
// the result is registered, then moved to the output register, and only then is
// the next input beat taken, so the block takes no new beat before it is through
// with the last one; the length of the cell row sets how long a query runs. A clear
// or an unused code sets its result on acceptance and then moves it to the output.
// The input channel takes a new beat while an earlier result still waits on
// the output. If the receiver stalls, the next result is held inside the
// block and no further input beat is taken until the output register frees.
// Reset empties the store, returns the write slot to zero and sets timeout_ms
// to 1000. timeout_ms sits at byte address 0 of the APB port; write it only
// while the block is idle.
module replay_seen_filter_with_expiry_core #(
    parameter int REPLAY_DEPTH = 256
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [1:0]                 s_func,
    input  logic [rsf_pkg::SEQ_W-1:0]  s_seq,
    input  logic [rsf_pkg::TIME_W-1:0] s_now_ms,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic                       m_fresh,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [1:0]                 paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);
    import rsf_pkg::*;

    localparam int SLOT_W = (REPLAY_DEPTH > 1) ? $clog2(REPLAY_DEPTH) : 1;

    localparam logic [TMO_W-1:0] TIMEOUT_RESET = TMO_W'(1000);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DONE
    } state_t;

    state_t            state_reg;
    state_t            state_next;
    logic [1:0]        func_reg;
    logic [1:0]        func_next;
    logic [SEQ_W-1:0]  seq_reg;
    logic [SEQ_W-1:0]  seq_next;
    logic [TIME_W-1:0] now_reg;
    logic [TIME_W-1:0] now_next;
    logic              res_reg;
    logic              res_next;
    logic [SLOT_W-1:0] slot_reg;
    logic [SLOT_W-1:0] slot_next;
    tok_t              launch_reg;
    tok_t              launch_next;
    logic [TMO_W-1:0]  timeout_reg;
    logic [TMO_W-1:0]  timeout_next;
    logic              m_valid_reg;
    logic              m_valid_next;
    logic              m_fresh_reg;
    logic              m_fresh_next;

    logic              clr_all;
    logic              wr_go;
    tok_t              chain [0:REPLAY_DEPTH];

    assign chain[0] = launch_reg;

    for (genvar i = 0; i < REPLAY_DEPTH; i++) begin : g_cell
        rsf_cell u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .tok_in     (chain[i]),
            .tok_out    (chain[i+1]),
            .clr_all    (clr_all),
            .wr_en      (wr_go && (slot_reg == SLOT_W'(i))),
            .wr_seq     (seq_reg),
            .wr_time    (now_reg),
            .timeout_ms (timeout_reg)
        );
    end

    always_comb begin
        state_next      = state_reg;
        func_next       = func_reg;
        seq_next        = seq_reg;
        now_next        = now_reg;
        res_next        = res_reg;
        slot_next       = slot_reg;
        launch_next     = launch_reg;
        launch_next.vld = 1'b0;
        timeout_next    = timeout_reg;
        m_valid_next    = m_valid_reg;
        m_fresh_next    = m_fresh_reg;
        clr_all         = 1'b0;
        wr_go           = 1'b0;

        if (psel && penable && pwrite && (paddr == ADDR_TIMEOUT)) begin
            timeout_next = pwdata;
        end

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    func_next = s_func;
                    seq_next  = s_seq;
                    now_next  = s_now_ms;
                    case (s_func)
                        FUNC_CHECK, FUNC_MARK: begin
                            launch_next.vld = 1'b1;
                            launch_next.seq = s_seq;
                            launch_next.now = s_now_ms;
                            launch_next.hit = 1'b0;
                            state_next      = ST_RUN;
                        end
                        FUNC_CLEAR: begin
                            clr_all    = 1'b1;
                            slot_next  = '0;
                            res_next   = 1'b0;
                            state_next = ST_DONE;
                        end
                        default: begin
                            res_next   = 1'b0;
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end
            ST_RUN: begin
                if (chain[REPLAY_DEPTH].vld) begin
                    res_next = ~chain[REPLAY_DEPTH].hit;
                    if ((func_reg == FUNC_MARK) && !chain[REPLAY_DEPTH].hit) begin
                        wr_go = 1'b1;
                        if (slot_reg == SLOT_W'(REPLAY_DEPTH - 1)) begin
                            slot_next = '0;
                        end else begin
                            slot_next = slot_reg + SLOT_W'(1);
                        end
                    end
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_fresh_next = res_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        func_reg        <= func_next;
        seq_reg         <= seq_next;
        now_reg         <= now_next;
        res_reg         <= res_next;
        m_fresh_reg     <= m_fresh_next;
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            slot_reg    <= '0;
            launch_reg  <= '0;
            timeout_reg <= TIMEOUT_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            slot_reg    <= slot_next;
            launch_reg  <= launch_next;
            timeout_reg <= timeout_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_fresh = m_fresh_reg;
    assign pready  = 1'b1;
    assign prdata  = (paddr == ADDR_TIMEOUT) ? timeout_reg : '0;

endmodule
